>>> hw/rtl/wsf_pkg.sv
// Shared types, constants and helper functions for the WAV stream framer.
// Used by the top level, wsf_front and wsf_back; depends on nothing.
package wsf_pkg;

   // Field widths fixed by the stream format.
   localparam int SCOUNT_W = 30;
   localparam int RATE_W   = 20;
   localparam int CHAN_W   = 8;
   localparam int FMT_W    = 2;
   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int NBYTES_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ALIGN_W  = 10;
   localparam int BRATE_W  = 30;
   localparam int BEAT_W   = 5;

   // Default queue depths handed down from the top level.
   localparam int CMD_DEPTH_DEF = 4;
   localparam int RSP_DEPTH_DEF = 4;

   // Request opcodes.
   localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_END    = 2'd2;

   // Sample format codes; any other code behaves as 32-bit.
   localparam logic [FMT_W-1:0] FMT_S16 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_S24 = 2'd1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT       = 3'd3;

   // Configuration reset values.
   localparam logic [SCOUNT_W-1:0] RST_SAMPLE_COUNT = '0;
   localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE  = 20'd48000;
   localparam logic [CHAN_W-1:0]   RST_CHANNELS     = 8'd2;
   localparam logic [FMT_W-1:0]    RST_FORMAT       = FMT_S16;

   // Byte counts of a beat.
   localparam logic [NBYTES_W-1:0] NB_1 = 3'd1;
   localparam logic [NBYTES_W-1:0] NB_2 = 3'd2;
   localparam logic [NBYTES_W-1:0] NB_3 = 3'd3;
   localparam logic [NBYTES_W-1:0] NB_4 = 3'd4;

   // Chunk tags, first character in the low byte.
   localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [WORD_W-1:0] TAG_FACT = 32'h7463_6166;
   localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

   // Header field values.
   localparam logic [15:0] FMT_TAG_PCM = 16'h0001;
   localparam logic [15:0] FMT_TAG_EXT = 16'hFFFE;
   localparam logic [15:0] EXT_SIZE    = 16'd22;
   localparam logic [WORD_W-1:0] FMT_SIZE_PCM = 32'd16;
   localparam logic [WORD_W-1:0] FMT_SIZE_EXT = 32'd40;
   localparam logic [WORD_W-1:0] FACT_SIZE    = 32'd4;
   localparam logic [WORD_W-1:0] RIFF_BASE_PCM = 32'd36;
   localparam logic [WORD_W-1:0] RIFF_BASE_EXT = 32'd72;
   localparam logic [WORD_W-1:0] NO_CHANNEL_FRAMES = 32'hFFFF_FFFF;

   // Sub-format GUID, led by the PCM format tag, in stream order.
   localparam logic [WORD_W-1:0] GUID_W0 = 32'h0000_0001;
   localparam logic [WORD_W-1:0] GUID_W1 = 32'h0010_0000;
   localparam logic [WORD_W-1:0] GUID_W2 = 32'hAA00_0080;
   localparam logic [WORD_W-1:0] GUID_W3 = 32'h719B_3800;

   // Header beat positions. The short header skips the extension beats and
   // jumps from the block-align beat straight to the data chunk.
   localparam logic [BEAT_W-1:0] SEL_EXT_FIRST = 5'd9;
   localparam logic [BEAT_W-1:0] SEL_SKIP      = 5'd9;
   localparam logic [BEAT_W-1:0] SEL_FRAMES    = 5'd17;
   localparam logic [BEAT_W-1:0] SEL_LAST      = 5'd19;

   // Configuration snapshot seen by the back end.
   typedef struct packed {
      logic [SCOUNT_W-1:0] sample_count;
      logic [RATE_W-1:0]   rate_hz;
      logic [CHAN_W-1:0]   channel_count;
      logic [FMT_W-1:0]    sample_format;
   } cfg_type;

   // Input and result payloads.
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   out_word;
      logic [NBYTES_W-1:0] out_bytes;
      logic                last;
   } rsp_type;

   // Commands from the front end to the back end.
   typedef enum logic {
      CMD_BEAT,
      CMD_HEADER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [WORD_W-1:0]   word;
      logic [NBYTES_W-1:0] nbytes;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic {
      BK_IDLE,
      BK_HDR
   } bk_state_type;

   // Speaker position mask for the common channel layouts.
   function automatic logic [WORD_W-1:0] speaker_mask(input logic [CHAN_W-1:0] ch);
      logic [WORD_W-1:0] m;
      begin
         case (ch)
            8'd1:    m = 32'h004;
            8'd2:    m = 32'h003;
            8'd4:    m = 32'h033;
            8'd6:    m = 32'h03F;
            8'd8:    m = 32'h63F;
            default: m = '0;
         endcase
         return m;
      end
   endfunction

endpackage

>>> hw/rtl/wav_stream_framer_top.sv
// Top level of the WAV stream framer: front end, command queue, back end, result queue.
// Depends on wsf_pkg, wsf_fifo, wsf_front and wsf_back.
//
//   Channel   Ports                                  Handshake
//   request   req_push, req_full, req_data           push while not full
//   result    rsp_empty, rsp_pop, rsp_data           pop while not empty
//   config    csr_valid, csr_ready, csr_index/wdata  valid and ready
//
// The front end hands a sample or end request to the command queue in the same cycle
// it is accepted; sample beats then pass through the command queue and the back end
// into the result queue, and stream at one per cycle while the result queue has room
// and no header is in progress. The extended header waits at its frame count beat for
// the 30-step frame count divider in the back end.
// Reset is synchronous; it clears both queues, the parity flag and the configuration
// and sequencer state registers. Requests stall when the command queue fills, behind
// a header in progress or behind a full result queue.
module wav_stream_framer_top #(
   parameter int CMD_DEPTH = wsf_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = wsf_pkg::RSP_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  wsf_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output wsf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wsf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wsf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   wsf_pkg::cfg_type cfg;
   wsf_pkg::cmd_type cmd_wr, cmd_rd;
   wsf_pkg::rsp_type rsp_wr;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic             rsp_push, rsp_full;

   wsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cmd_push  (cmd_push),
      .cmd_item  (cmd_wr),
      .cmd_full  (cmd_full)
   );

   // Command queue between front and back end.
   wsf_fifo #(
      .WIDTH ($bits(wsf_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty)
   );

   wsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_item  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_wr),
      .rsp_full  (rsp_full)
   );

   // Result queue toward the consumer.
   wsf_fifo #(
      .WIDTH ($bits(wsf_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

>>> hw/rtl/wsf_fifo.sv
// Small synchronous first-in first-out queue of flip-flops.
// Generic; no package dependency.
module wsf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> hw/rtl/wsf_div.sv
// Restoring divider, one quotient bit per cycle, for the fact chunk frame count.
// Generic; no package dependency.
module wsf_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W+1:0] diff;
   logic             ge;

   // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign ge     = !diff[DVS_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/wsf_front.sv
// Front end: configuration registers, request acceptance, sample packing and pad decision.
// Depends on wsf_pkg.
module wsf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  wsf_pkg::req_type                    req_data,
   output logic                                req_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wsf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wsf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output wsf_pkg::cfg_type                    cfg,
   output logic                                cmd_push,
   output wsf_pkg::cmd_type                    cmd_item,
   input  logic                                cmd_full
);

   wsf_pkg::cfg_type cfg_ff, cfg_in;
   logic             parity_ff, parity_in;
   logic             accept;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign cfg       = cfg_ff;

   // Register writes; out-of-range fields are truncated to the register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            wsf_pkg::CSR_SAMPLE_COUNT:
               cfg_in.sample_count = csr_wdata[wsf_pkg::SCOUNT_W-1:0];
            wsf_pkg::CSR_SAMPLE_RATE:
               cfg_in.rate_hz = csr_wdata[wsf_pkg::RATE_W-1:0];
            wsf_pkg::CSR_CHANNELS:
               cfg_in.channel_count = csr_wdata[wsf_pkg::CHAN_W-1:0];
            wsf_pkg::CSR_FORMAT:
               cfg_in.sample_format = csr_wdata[wsf_pkg::FMT_W-1:0];
            default: ;
         endcase
      end
   end

   // Classify the request: header command, ready-made beat, or nothing.
   always_comb begin
      cmd_push        = 1'b0;
      cmd_item.kind   = wsf_pkg::CMD_BEAT;
      cmd_item.word   = '0;
      cmd_item.nbytes = wsf_pkg::NB_1;
      parity_in       = parity_ff;
      if (accept) begin
         unique case (req_data.op)
            wsf_pkg::OP_HEADER: begin
               cmd_push      = 1'b1;
               cmd_item.kind = wsf_pkg::CMD_HEADER;
               parity_in     = 1'b0;
            end
            wsf_pkg::OP_SAMPLE: begin
               cmd_push  = 1'b1;
               parity_in = !parity_ff;
               if (cfg_ff.sample_format == wsf_pkg::FMT_S16) begin
                  cmd_item.word   = {16'h0000, req_data.sample_value[15:0]};
                  cmd_item.nbytes = wsf_pkg::NB_2;
               end else if (cfg_ff.sample_format == wsf_pkg::FMT_S24) begin
                  cmd_item.word   = {8'h00, req_data.sample_value[31:8]};
                  cmd_item.nbytes = wsf_pkg::NB_3;
               end else begin
                  cmd_item.word   = req_data.sample_value;
                  cmd_item.nbytes = wsf_pkg::NB_4;
               end
            end
            wsf_pkg::OP_END: begin
               // A single zero pad byte follows an odd run of 24-bit samples.
               cmd_push  = (cfg_ff.sample_format == wsf_pkg::FMT_S24) && parity_ff;
               parity_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count   <= wsf_pkg::RST_SAMPLE_COUNT;
         cfg_ff.rate_hz        <= wsf_pkg::RST_SAMPLE_RATE;
         cfg_ff.channel_count  <= wsf_pkg::RST_CHANNELS;
         cfg_ff.sample_format  <= wsf_pkg::RST_FORMAT;
         parity_ff             <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         parity_ff <= parity_in;
      end
   end

endmodule

>>> hw/rtl/wsf_back.sv
// Back end: forwards sample beats and sequences the header beats.
// Depends on wsf_pkg and wsf_div.
module wsf_back (
   input  logic             clock,
   input  logic             reset,
   input  wsf_pkg::cfg_type cfg,
   input  wsf_pkg::cmd_type cmd_item,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             rsp_push,
   output wsf_pkg::rsp_type rsp_item,
   input  logic             rsp_full
);

   wsf_pkg::bk_state_type                state_ff, state_in;
   logic [wsf_pkg::BEAT_W-1:0]           beat_ff, beat_in;
   logic [wsf_pkg::WORD_W-1:0]           data_size_ff, data_size_in;
   logic [wsf_pkg::ALIGN_W-1:0]          align_ff, align_in;
   logic [wsf_pkg::NBYTES_W-1:0]         bps_ff, bps_in;
   logic                                 ext_ff, ext_in;
   logic [wsf_pkg::BRATE_W-1:0]          byte_rate_ff;
   logic [wsf_pkg::BEAT_W-1:0]           sel;
   logic [wsf_pkg::WORD_W-1:0]           hdr_word;
   logic [wsf_pkg::WORD_W-1:0]           riff_size;
   logic [wsf_pkg::WORD_W-1:0]           frames;
   logic [15:0]                          bits16;
   logic                                 div_start;
   logic                                 div_done;
   logic [wsf_pkg::SCOUNT_W-1:0]         div_quo;
   logic                                 hdr_ready;

   // Frame count divider runs alongside the first header beats.
   wsf_div #(
      .DVD_W (wsf_pkg::SCOUNT_W),
      .DVS_W (wsf_pkg::CHAN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.sample_count),
      .divisor  (cfg.channel_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Derived sizes captured when a header starts.
   always_comb begin
      if (cfg.sample_format == wsf_pkg::FMT_S16) begin
         bps_in       = wsf_pkg::NB_2;
         data_size_in = {1'b0, cfg.sample_count, 1'b0};
         align_in     = {1'b0, cfg.channel_count, 1'b0};
      end else if (cfg.sample_format == wsf_pkg::FMT_S24) begin
         bps_in       = wsf_pkg::NB_3;
         data_size_in = {2'b00, cfg.sample_count} + {1'b0, cfg.sample_count, 1'b0};
         align_in     = {2'b00, cfg.channel_count} + {1'b0, cfg.channel_count, 1'b0};
      end else begin
         bps_in       = wsf_pkg::NB_4;
         data_size_in = {cfg.sample_count, 2'b00};
         align_in     = {cfg.channel_count, 2'b00};
      end
      ext_in = (cfg.channel_count > 8'd2) || (cfg.sample_format != wsf_pkg::FMT_S16);
   end

   // Header field values from the captured sizes.
   assign bits16    = {10'h000, bps_ff, 3'b000};
   assign riff_size = (ext_ff ? wsf_pkg::RIFF_BASE_EXT : wsf_pkg::RIFF_BASE_PCM)
                      + data_size_ff + {31'h0, data_size_ff[0]};
   assign frames    = (cfg.channel_count == '0) ? wsf_pkg::NO_CHANNEL_FRAMES
                      : {{(wsf_pkg::WORD_W - wsf_pkg::SCOUNT_W){1'b0}}, div_quo};
   assign sel       = (!ext_ff && (beat_ff >= wsf_pkg::SEL_EXT_FIRST))
                      ? beat_ff + wsf_pkg::SEL_SKIP : beat_ff;
   assign hdr_ready = (sel != wsf_pkg::SEL_FRAMES) || div_done;

   // Header beat selection, in stream order.
   always_comb begin
      unique case (sel)
         5'd0:  hdr_word = wsf_pkg::TAG_RIFF;
         5'd1:  hdr_word = riff_size;
         5'd2:  hdr_word = wsf_pkg::TAG_WAVE;
         5'd3:  hdr_word = wsf_pkg::TAG_FMT;
         5'd4:  hdr_word = ext_ff ? wsf_pkg::FMT_SIZE_EXT : wsf_pkg::FMT_SIZE_PCM;
         5'd5:  hdr_word = {8'h00, cfg.channel_count,
                            ext_ff ? wsf_pkg::FMT_TAG_EXT : wsf_pkg::FMT_TAG_PCM};
         5'd6:  hdr_word = {12'h000, cfg.rate_hz};
         5'd7:  hdr_word = {2'b00, byte_rate_ff};
         5'd8:  hdr_word = {bits16, 6'h00, align_ff};
         5'd9:  hdr_word = {bits16, wsf_pkg::EXT_SIZE};
         5'd10: hdr_word = wsf_pkg::speaker_mask(cfg.channel_count);
         5'd11: hdr_word = wsf_pkg::GUID_W0;
         5'd12: hdr_word = wsf_pkg::GUID_W1;
         5'd13: hdr_word = wsf_pkg::GUID_W2;
         5'd14: hdr_word = wsf_pkg::GUID_W3;
         5'd15: hdr_word = wsf_pkg::TAG_FACT;
         5'd16: hdr_word = wsf_pkg::FACT_SIZE;
         5'd17: hdr_word = frames;
         5'd18: hdr_word = wsf_pkg::TAG_DATA;
         5'd19: hdr_word = data_size_ff;
         default: hdr_word = '0;
      endcase
   end

   // Sequencer: sample and pad beats pass straight through, a header walks its beats.
   always_comb begin
      state_in           = state_ff;
      beat_in            = beat_ff;
      cmd_pop            = 1'b0;
      rsp_push           = 1'b0;
      div_start          = 1'b0;
      rsp_item.out_word  = cmd_item.word;
      rsp_item.out_bytes = cmd_item.nbytes;
      rsp_item.last      = 1'b1;
      unique case (state_ff)
         wsf_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_item.kind == wsf_pkg::CMD_HEADER) begin
                  cmd_pop   = 1'b1;
                  div_start = 1'b1;
                  beat_in   = '0;
                  state_in  = wsf_pkg::BK_HDR;
               end else if (!rsp_full) begin
                  cmd_pop  = 1'b1;
                  rsp_push = 1'b1;
               end
            end
         end
         wsf_pkg::BK_HDR: begin
            rsp_item.out_word  = hdr_word;
            rsp_item.out_bytes = wsf_pkg::NB_4;
            rsp_item.last      = (sel == wsf_pkg::SEL_LAST);
            if (!rsp_full && hdr_ready) begin
               rsp_push = 1'b1;
               beat_in  = beat_ff + 1'b1;
               if (sel == wsf_pkg::SEL_LAST) begin
                  state_in = wsf_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = wsf_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsf_pkg::BK_IDLE;
         beat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
      end
   end

   // Header size registers; the byte rate product is taken from the captured alignment.
   always_ff @(posedge clock) begin
      if (div_start) begin
         data_size_ff <= data_size_in;
         align_ff     <= align_in;
         bps_ff       <= bps_in;
         ext_ff       <= ext_in;
      end
      byte_rate_ff <= {20'h00000, align_ff} * {10'h000, cfg.rate_hz};
   end

endmodule
